### hw/rtl/pwm_duty_angle_decoder_macros.svh
// Assertion macros for the PWM duty angle decoder checker.
// No dependencies.
`ifndef PWM_DUTY_ANGLE_DECODER_MACROS_SVH
`define PWM_DUTY_ANGLE_DECODER_MACROS_SVH

// implication in the same cycle, off during reset
`define PDAD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdad assertion failed");

// implication into the next cycle, off during reset
`define PDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdad assertion failed");

// implication into the next cycle, also checked during reset
`define PDAD_ASSERT_NEXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pdad assertion failed");

`endif

### hw/rtl/pdad_pkg.sv
// Shared types and constants of the PWM duty angle decoder.
// No dependencies.
package pdad_pkg;

  localparam int TIME_BITS  = 32;
  localparam int SCALE_BITS = 16;
  localparam int POS_BITS   = 12;
  localparam int ZERO_BITS  = 19;
  localparam int ANGLE_BITS = 18;
  localparam int PROD_BITS  = TIME_BITS + SCALE_BITS;
  localparam int ANG_WORK_BITS = 20;
  localparam int ADDR_BITS  = 4;

  localparam int MUL_STEPS = SCALE_BITS;
  localparam int DIV_STEPS = PROD_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  localparam int HALF_TURN = 92160;
  localparam int FULL_TURN = 184320;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 16'd4351;
  localparam logic [POS_BITS-1:0]   OFFSET_RESET = 12'd128;
  localparam logic [POS_BITS-1:0]   MAX_RESET    = 12'd4095;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_OFFSET = 2'd1,
    REG_MAX    = 2'd2,
    REG_ZERO   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_ANGLE,
    ST_WRAP1,
    ST_WRAP2,
    ST_DONE
  } state_t;

  function automatic logic signed [ANG_WORK_BITS-1:0] wrap_step(
      input logic signed [ANG_WORK_BITS-1:0] a);
    logic signed [ANG_WORK_BITS-1:0] r;
    r = a;
    if (a > ANG_WORK_BITS'(HALF_TURN)) begin
      r = a - ANG_WORK_BITS'(FULL_TURN);
    end else if (a < -ANG_WORK_BITS'(HALF_TURN)) begin
      r = a + ANG_WORK_BITS'(FULL_TURN);
    end
    return r;
  endfunction

endpackage

### hw/rtl/pwm_duty_angle_decoder.sv
// PWM duty angle decoder: bit-serial multiply, restoring divide, clamp, angle.
// A rising edge with nonzero period starts a request: 16 multiply steps, 48 divide
// steps, then clamp, angle, wrap1, wrap2 and done before the result is registered.
// Such a request holds cap_stall until done; others are taken 1 per cycle while idle.
// Synchronous reset clears timing state and sets the registers to their defaults. Depends on pdad_pkg.
module pwm_duty_angle_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cap_valid,
  output logic        cap_stall,
  input  logic [pdad_pkg::TIME_BITS-1:0] capture_time,
  input  logic        edge_rising,
  input  logic        edge_falling,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [pdad_pkg::POS_BITS-1:0]   position,
  output logic [pdad_pkg::ANGLE_BITS-1:0] angle_q9,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pdad_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pdad_pkg::*;

  logic [SCALE_BITS-1:0] period_scale;
  logic [POS_BITS-1:0]   position_offset;
  logic [POS_BITS-1:0]   position_max;
  logic [ZERO_BITS-1:0]  zero_angle;

  logic [TIME_BITS-1:0]  last_rise_time;
  logic [TIME_BITS-1:0]  high_width;

  state_t state, state_next;
  logic [CNT_BITS-1:0]   cnt;
  logic [SCALE_BITS-1:0] sreg;
  logic [TIME_BITS-1:0]  mul_w;
  logic [TIME_BITS-1:0]  div_p;
  logic [PROD_BITS-1:0]  acc;
  logic [TIME_BITS-1:0]  rem;
  logic [POS_BITS-1:0]   pos;
  logic signed [ANG_WORK_BITS-1:0] ang;

  logic accept, start, wr;
  reg_idx_t widx, ridx;
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS:0]   rem_sh;
  logic                 qbit;
  logic [PROD_BITS-1:0] q_sub;
  logic [ANGLE_BITS-1:0] pos45;

  assign pready    = 1'b1;
  assign cap_stall = (state != ST_IDLE);
  assign accept    = cap_valid && !cap_stall;
  assign period    = capture_time - last_rise_time;
  assign start     = accept && edge_rising && (period != '0);

  assign wr   = psel && penable && pwrite && pready;
  assign widx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign ridx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_comb begin
    unique case (ridx)
      REG_SCALE:  prdata = 32'(period_scale);
      REG_OFFSET: prdata = 32'(position_offset);
      REG_MAX:    prdata = 32'(position_max);
      REG_ZERO:   prdata = 32'(zero_angle);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_scale    <= SCALE_RESET;
      position_offset <= OFFSET_RESET;
      position_max    <= MAX_RESET;
      zero_angle      <= '0;
    end else if (wr) begin
      unique case (widx)
        REG_SCALE:  period_scale    <= pwdata[SCALE_BITS-1:0];
        REG_OFFSET: position_offset <= pwdata[POS_BITS-1:0];
        REG_MAX:    position_max    <= pwdata[POS_BITS-1:0];
        REG_ZERO:   zero_angle      <= pwdata[ZERO_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // edge timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rise_time <= '0;
      high_width     <= '0;
    end else if (accept) begin
      if (edge_rising) begin
        last_rise_time <= capture_time;
      end
      if (edge_falling) begin
        high_width <= edge_rising ? '0 : period;
      end
    end
  end

  // divide step: product bits shift into the remainder, quotient bits into acc
  assign rem_sh = {rem, acc[PROD_BITS-1]};
  assign qbit   = (rem_sh >= {1'b0, div_p});
  assign q_sub  = acc - PROD_BITS'(position_offset);
  assign pos45  = ({pos, 5'd0} + {2'd0, pos, 3'd0}) + ({3'd0, pos, 2'd0} + {6'd0, pos});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_MUL;
      ST_MUL:   if (cnt == CNT_BITS'(MUL_STEPS - 1)) state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_BITS'(DIV_STEPS - 1)) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_ANGLE;
      ST_ANGLE: state_next = ST_WRAP1;
      ST_WRAP1: state_next = ST_WRAP2;
      ST_WRAP2: state_next = ST_DONE;
      ST_DONE:  if (!res_valid || !res_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mul_w <= high_width;
        div_p <= period;
        sreg  <= period_scale;
        acc   <= '0;
        rem   <= '0;
      end
      ST_MUL: begin
        acc  <= {acc[PROD_BITS-2:0], 1'b0} +
                (sreg[SCALE_BITS-1] ? {{SCALE_BITS{1'b0}}, mul_w} : '0);
        sreg <= {sreg[SCALE_BITS-2:0], 1'b0};
      end
      ST_DIV: begin
        rem <= qbit ? TIME_BITS'(rem_sh - {1'b0, div_p}) : rem_sh[TIME_BITS-1:0];
        acc <= {acc[PROD_BITS-2:0], qbit};
      end
      ST_CLAMP: begin
        if (acc < PROD_BITS'(position_offset)) begin
          pos <= '0;
        end else if (q_sub > PROD_BITS'(position_max)) begin
          pos <= position_max;
        end else begin
          pos <= q_sub[POS_BITS-1:0];
        end
      end
      ST_ANGLE: ang <= $signed({2'b00, pos45}) -
                       ANG_WORK_BITS'($signed(zero_angle));
      ST_WRAP1: ang <= wrap_step(ang);
      ST_WRAP2: ang <= wrap_step(ang);
      ST_DONE:  ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res_valid || !res_stall)) begin
      position <= pos;
      angle_q9 <= ang[ANGLE_BITS-1:0];
    end
  end

endmodule

### hw/rtl/pdad_checker.sv
// Port-level checks for the PWM duty angle decoder, bound to the top level.
// Depends on pdad_pkg and pwm_duty_angle_decoder_macros.svh.
`include "pwm_duty_angle_decoder_macros.svh"

module pdad_checker (
  input logic        clk,
  input logic        rst,
  input logic        cap_valid,
  input logic        cap_stall,
  input logic        edge_rising,
  input logic        res_valid,
  input logic        res_stall,
  input logic [11:0] position,
  input logic [17:0] angle_q9
);
  import pdad_pkg::*;

  `PDAD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(position) && $stable(angle_q9))
  `PDAD_ASSERT_NEXT(a_no_rise_fast, clk, rst, cap_valid && !cap_stall && !edge_rising, !cap_stall)
  `PDAD_ASSERT_NOW(a_angle_range, clk, rst, res_valid, $signed(angle_q9) <= 18'sd92160 && $signed(angle_q9) >= -18'sd92160)
  `PDAD_ASSERT_NEXT_ALL(a_reset_clear, clk, rst, !res_valid && !cap_stall)

endmodule

bind pwm_duty_angle_decoder pdad_checker u_pdad_checker (
  .clk         (clk),
  .rst         (rst),
  .cap_valid   (cap_valid),
  .cap_stall   (cap_stall),
  .edge_rising (edge_rising),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .position    (position),
  .angle_q9    (angle_q9)
);

### tb/sv/pwm_duty_angle_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pwm_duty_angle_decoder: edge requests in, position/angle out.
// Holds its own position and angle predictor in a small scoreboard class.
// Depends on pdad_pkg and the decoder RTL.
module pwm_duty_angle_decoder_tb;
  import pdad_pkg::*;

  localparam int POSITION_STEPS = 4096;
  localparam int SETTLE_CYCLES  = 80;
  localparam int EDGE_TARGET    = 1000;
  localparam int CALM_FRAMES    = 75;

  typedef struct packed {
    logic [11:0] position;
    logic [17:0] angle;
  } pos_angle_t;

  class angle_board;
    logic [15:0]        scale      = SCALE_RESET;
    logic [11:0]        offset     = OFFSET_RESET;
    logic [11:0]        pos_max    = MAX_RESET;
    logic signed [18:0] zero       = '0;
    logic [31:0]        last_rise  = '0;
    logic [31:0]        high_width = '0;
    logic [11:0]        held       = '0;
    pos_angle_t         expected_angles[$];
    int                 errors     = 0;
    int                 results    = 0;

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SCALE:  scale = v[15:0];
        REG_OFFSET: offset = v[11:0];
        REG_MAX:    pos_max = v[11:0];
        REG_ZERO:   zero = v[18:0];
        default: ;
      endcase
    endfunction

    // rising edge first; a falling edge in the same request then measures zero
    function void note_edge(logic [31:0] t, bit rise, bit fall);
      logic [31:0]       period;
      longint unsigned   q;
      longint unsigned   p;
      int                ang;
      pos_angle_t        r;
      if (rise) begin
        period = t - last_rise;
        last_rise = t;
        if (period != 0) begin
          q = (64'(high_width) * 64'(scale)) / 64'(period);
          p = (q < 64'(offset)) ? 0 : q - 64'(offset);
          if (p > 64'(pos_max)) p = 64'(pos_max);
          held = p[11:0];
          ang = (int'(held) * FULL_TURN) / POSITION_STEPS - int'(zero);
          repeat (2) begin
            if (ang > HALF_TURN) ang -= FULL_TURN;
            else if (ang < -HALF_TURN) ang += FULL_TURN;
          end
          r.position = held;
          r.angle = ang[17:0];
          expected_angles.push_back(r);
        end
      end
      if (fall) high_width = t - last_rise;
    endfunction

    function void check_angle(logic [11:0] pos, logic [17:0] ang);
      pos_angle_t e;
      results++;
      if (expected_angles.size() == 0) begin
        $error("unexpected result: position %0d angle_q9 %0d", pos, $signed(ang));
        errors++;
        return;
      end
      e = expected_angles.pop_front();
      if (pos !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, pos);
        errors++;
      end
      if (ang !== e.angle) begin
        $error("angle_q9: expected %0d, got %0d", $signed(e.angle), $signed(ang));
        errors++;
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cap_valid = 1'b0;
  logic        cap_stall;
  logic [31:0] capture_time = '0;
  logic        edge_rising = 1'b0;
  logic        edge_falling = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [11:0] position;
  logic [17:0] angle_q9;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  angle_board  sb;
  int          n_edges = 0;
  int          n_settings = 0;
  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  logic [31:0] t_cursor;

  pwm_duty_angle_decoder dut (
    .clk(clk), .rst(rst),
    .cap_valid(cap_valid), .cap_stall(cap_stall),
    .capture_time(capture_time), .edge_rising(edge_rising), .edge_falling(edge_falling),
    .res_valid(res_valid), .res_stall(res_stall),
    .position(position), .angle_q9(angle_q9),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!gaps_on) begin
      res_stall <= 1'b0;
    end else if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_angle(position, angle_q9);
  end

  task automatic edge_req(input logic [31:0] t, input bit r, input bit f);
    cap_valid <= 1'b1;
    capture_time <= t;
    edge_rising <= r;
    edge_falling <= f;
    @(posedge clk);
    while (cap_stall) @(posedge clk);
    sb.note_edge(t, r, f);
    if (r | f) n_edges++;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      cap_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    cap_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
    n_settings++;
    @(posedge clk);
  endtask

  task automatic cfg_all(input logic [31:0] s, input logic [31:0] o,
                         input logic [31:0] m, input int z);
    cfg_write(REG_SCALE, s);
    cfg_write(REG_OFFSET, o);
    cfg_write(REG_MAX, m);
    cfg_write(REG_ZERO, 32'(z));
  endtask

  task automatic random_config();
    logic [31:0] v;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0: v = 0;
        1: v = 1;
        2: v = 32'hFFFF;
        3: v = 32'(SCALE_RESET);
        default: v = $urandom_range(1, 65535);
      endcase
      cfg_write(REG_SCALE, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 4095;
        2, 3: v = $urandom_range(0, 300);
        default: v = $urandom_range(0, 4095);
      endcase
      cfg_write(REG_OFFSET, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0: v = 0;
        1: v = 4095;
        2: v = $urandom_range(0, 4095);
        default: v = $urandom_range(2048, 4095);
      endcase
      cfg_write(REG_MAX, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 6))
        0: v = 32'(-FULL_TURN);
        1: v = 32'(FULL_TURN);
        2: v = $urandom_range(0, 32'h7FFFF);
        3: v = 0;
        default: v = 32'($urandom_range(0, 2 * FULL_TURN)) - 32'(FULL_TURN);
      endcase
      cfg_write(REG_ZERO, v);
    end
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      7: return $urandom_range(1, 16);
      8: return $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
      9: return $urandom_range(5000, 32'h0010_0000);
      default: return $urandom_range(16, 5000);
    endcase
  endfunction

  // mostly clean frames (rise, then fall inside the frame), some noise
  task automatic random_action();
    logic [31:0] p;
    logic [31:0] w;
    logic [31:0] t;
    int          k;
    k = $urandom_range(0, 99);
    p = pick_period();
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = p;
      default: w = $urandom_range(0, p);
    endcase
    if (k < 75) begin
      edge_req(t_cursor, 1'b1, 1'b0);
      edge_req(t_cursor + w, 1'b0, 1'b1);
      t_cursor = t_cursor + p;
    end else if (k < 82) begin
      edge_req(t_cursor, 1'b1, 1'b1);
      t_cursor = t_cursor + p;
    end else if (k < 88) begin
      edge_req(sb.last_rise, 1'b1, 1'($urandom_range(0, 1)));
    end else if (k < 93) begin
      edge_req($urandom, 1'b0, 1'b0);
    end else begin
      t = $urandom;
      edge_req(t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      t_cursor = t + $urandom_range(1, 5000);
    end
  endtask

  initial begin
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero period from reset, below-offset, clamp, timer wrap
    edge_req(32'd0, 1'b1, 1'b0);
    edge_req(32'd1000, 1'b0, 1'b1);
    edge_req(32'd4000, 1'b1, 1'b0);
    edge_req(32'hFFFF_FFFF, 1'b0, 1'b0);
    edge_req(32'd4000, 1'b0, 1'b1);
    edge_req(32'd8000, 1'b1, 1'b0);
    edge_req(32'd8000, 1'b1, 1'b0);
    edge_req(32'hFFFF_FFFF, 1'b0, 1'b1);
    edge_req(32'd8010, 1'b1, 1'b0);
    edge_req(32'hFFFF_FFF0, 1'b1, 1'b1);
    edge_req(32'h0000_0010, 1'b1, 1'b0);
    edge_req(32'h8000_000F, 1'b0, 1'b1);
    edge_req(32'h0000_000F, 1'b1, 1'b0);
    settle();

    // far negative zero reference: needs two wrap steps
    cfg_all(32'hFFFF, 0, 4095, -FULL_TURN);
    edge_req(32'd1015, 1'b0, 1'b1);
    edge_req(32'd1016, 1'b1, 1'b0);
    edge_req(32'd1516, 1'b0, 1'b1);
    edge_req(32'd3016, 1'b1, 1'b0);
    settle();

    cfg_all(0, 4095, 0, FULL_TURN);
    edge_req(32'd3500, 1'b0, 1'b1);
    edge_req(32'd5000, 1'b1, 1'b0);
    settle();

    cfg_all(32'(SCALE_RESET), 32'(OFFSET_RESET), 4095, -262144);
    edge_req(32'd5900, 1'b0, 1'b1);
    edge_req(32'd6000, 1'b1, 1'b0);
    edge_req(32'd6050, 1'b0, 1'b1);
    edge_req(32'd7000, 1'b1, 1'b0);
    settle();

    t_cursor = $urandom;
    while (n_edges < EDGE_TARGET) begin
      random_config();
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(30, 120)) random_action();
      settle();
    end

    gaps_on = 1'b0;
    random_config();
    repeat (CALM_FRAMES) random_action();
    settle();

    $display("Covered %0d edge requests, %0d decoded results, %0d register writes;",
             n_edges, sb.results, n_settings);
    $display("zero periods, dual edges, timer wrap, clamps and far zero references included.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pdad_pkg.sv
hw/rtl/pwm_duty_angle_decoder.sv
hw/rtl/pdad_checker.sv
tb/sv/pwm_duty_angle_decoder_tb.sv
